// ===== hdl/sks_pkg.sv =====
// shared constants and codes for the sorted key set
`default_nettype none

package sks_pkg;

  // payload widths of the channels
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 9;

  // default store geometry
  localparam int unsigned CAPACITY_DEF  = 256;
  localparam int unsigned KEY_WIDTH_DEF = 32;

  // operation codes
  localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

endpackage

`default_nettype wire

// ===== hdl/sks_if.sv =====
// channel interfaces of the sorted key set: configuration, request, response
`default_nettype none

interface sks_cfg_if;
  logic valid;
  logic ready;
  logic signed_order;

  modport source (output valid, output signed_order, input ready);
  modport sink (input valid, input signed_order, output ready);
endinterface

interface sks_req_if;
  logic                      valid;
  logic                      ready;
  logic [sks_pkg::OP_W-1:0]  op;
  logic [sks_pkg::KEY_W-1:0] key;

  modport source (output valid, output op, output key, input ready);
  modport sink (input valid, input op, input key, output ready);
endinterface

interface sks_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [sks_pkg::POS_W-1:0]    position;
  logic [sks_pkg::STATUS_W-1:0] status;
  logic [sks_pkg::OCC_W-1:0]    occupancy;

  modport source (output valid, output found, output position, output status,
                  output occupancy, input ready);
  modport sink (input valid, input found, input position, input status,
                input occupancy, output ready);
endinterface

`default_nettype wire

// ===== hdl/sorted_key_set_top.sv =====
// sorted key set: ordered store of distinct keys with find, add and delete
//
// channels: cfg writes signed_order (0 unsigned, 1 two's complement ordering),
// one transaction per cycle, always ready; req carries op and key; rsp returns
// found, position, status and occupancy, one transaction per request.
// one request is worked at a time: req.ready is high only while the sequencer
// is idle. a binary search runs over a single-port key memory with registered
// read data, one compare unit, each search step a read and then a compare.
// add and delete then move the keys above the slot one by one through the
// same memory port, each moved key a read and then a write.
// the search takes at most ceil(log2(CAPACITY + 1)) steps; no key is moved
// for a find, an add of a present key or to a full store, or a delete that
// misses. the sequencer is idle again, and takes the next request, in the
// cycle after the response is loaded.
// the response sits in an output register; a new request is taken while it
// waits, and that request's result holds in the done state until rsp frees.
// reset (rst, synchronous) empties the set and selects unsigned ordering; the
// key memory is not cleared, contents at or above the count are never used.
`default_nettype none

module sorted_key_set_top #(
  parameter int unsigned CAPACITY  = sks_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_WIDTH = sks_pkg::KEY_WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  sks_cfg_if.sink    cfg,
  sks_req_if.sink    req,
  sks_rsp_if.source  rsp
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [KEY_WIDTH-1:0] SIGN_BIT = KEY_WIDTH'(1) << (KEY_WIDTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_CMP,
    S_DECIDE,
    S_MRD,
    S_MWR,
    S_INS,
    S_DONE
  } state_t;

  state_t                        state;
  logic                          signed_order;
  logic [sks_pkg::OP_W-1:0]      op;
  logic [KEY_WIDTH-1:0]          skey;     // key as stored
  logic [KEY_WIDTH-1:0]          kord;     // key mapped to unsigned order
  logic [CW-1:0]                 lo;
  logic [CW-1:0]                 hi;       // ends as the slot
  logic                          hit;
  logic [AW-1:0]                 ptr;      // move pointer (source slot)
  logic [CW-1:0]                 count;
  logic [sks_pkg::STATUS_W-1:0]  status;

  logic                          rsp_valid;
  logic                          rsp_found;
  logic [sks_pkg::POS_W-1:0]     rsp_position;
  logic [sks_pkg::STATUS_W-1:0]  rsp_status;
  logic [sks_pkg::OCC_W-1:0]     rsp_occupancy;

  // key memory, single port, registered read
  logic [KEY_WIDTH-1:0]          mem [CAPACITY];
  logic [KEY_WIDTH-1:0]          rdata;
  logic [AW-1:0]                 raddr;
  logic                          we;
  logic [AW-1:0]                 waddr;
  logic [KEY_WIDTH-1:0]          wdata;

  logic [KEY_WIDTH-1:0]          key_used;
  logic [KEY_WIDTH-1:0]          flip;
  logic [KEY_WIDTH-1:0]          mord;
  logic [CW:0]                   sum;
  logic [CW-1:0]                 mid;
  logic [CW-1:0]                 cnt_m1;
  logic [CW-1:0]                 slot_p1;
  logic [31:0]                   hi_wide;
  logic [31:0]                   cnt_wide;
  logic                          is_add;

  // the low KEY_WIDTH bits of the key take part, or the key zero-extended when KEY_WIDTH > KEY_W
  if (KEY_WIDTH <= sks_pkg::KEY_W) begin : g_key_narrow
    assign key_used = req.key[KEY_WIDTH-1:0];
  end else begin : g_key_wide
    assign key_used = {{(KEY_WIDTH - sks_pkg::KEY_W){1'b0}}, req.key};
  end

  // signed ordering is unsigned ordering with the sign bit flipped
  assign flip    = signed_order ? SIGN_BIT : '0;
  assign mord    = rdata ^ flip;
  assign sum     = {1'b0, lo} + {1'b0, hi};
  assign mid     = sum[CW:1];
  assign cnt_m1  = count - CW'(1);
  assign slot_p1 = hi + CW'(1);
  assign is_add  = (op == sks_pkg::OP_ADD);

  assign hi_wide  = 32'(hi);
  assign cnt_wide = 32'(count);

  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE);

  assign rsp.valid     = rsp_valid;
  assign rsp.found     = rsp_found;
  assign rsp.position  = rsp_position;
  assign rsp.status    = rsp_status;
  assign rsp.occupancy = rsp_occupancy;

  // memory port control
  always_comb begin
    raddr = (state == S_SRCH) ? mid[AW-1:0] : ptr;
    we    = 1'b0;
    waddr = ptr;
    wdata = rdata;
    case (state)
      S_MWR: begin
        we    = 1'b1;
        waddr = is_add ? ptr + AW'(1) : ptr - AW'(1);
      end
      S_INS: begin
        we    = 1'b1;
        waddr = hi[AW-1:0];
        wdata = skey;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // sequencer, configuration and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      signed_order <= 1'b0;
      count        <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        signed_order <= cfg.signed_order;
      end
      // the done state reloads the response register itself
      if (rsp.ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op    <= req.op;
            skey  <= key_used;
            kord  <= key_used ^ flip;
            lo    <= '0;
            hi    <= count;
            hit   <= 1'b0;
            state <= S_SRCH;
          end
        end

        // loop test; the memory reads the middle slot on the way to compare
        S_SRCH: begin
          if (hi == lo || hit) begin
            state <= S_DECIDE;
          end else begin
            state <= S_CMP;
          end
        end

        S_CMP: begin
          if (kord <= mord) begin
            hi  <= mid;
            hit <= (kord == mord);
          end else begin
            lo <= mid + CW'(1);
          end
          state <= S_SRCH;
        end

        S_DECIDE: begin
          case (op)
            sks_pkg::OP_ADD: begin
              if (hit) begin
                status <= sks_pkg::STATUS_OK;
                state  <= S_DONE;
              end else if (count == FULL_COUNT) begin
                status <= sks_pkg::STATUS_FULL;
                state  <= S_DONE;
              end else if (count > hi) begin
                status <= sks_pkg::STATUS_OK;
                ptr    <= cnt_m1[AW-1:0];
                state  <= S_MRD;
              end else begin
                status <= sks_pkg::STATUS_OK;
                state  <= S_INS;
              end
            end
            sks_pkg::OP_DELETE: begin
              if (!hit) begin
                status <= sks_pkg::STATUS_MISS;
                state  <= S_DONE;
              end else if (slot_p1 < count) begin
                status <= sks_pkg::STATUS_OK;
                ptr    <= slot_p1[AW-1:0];
                state  <= S_MRD;
              end else begin
                status <= sks_pkg::STATUS_OK;
                count  <= cnt_m1;
                state  <= S_DONE;
              end
            end
            default: begin
              // find, and the unused code behaves as find
              status <= hit ? sks_pkg::STATUS_OK : sks_pkg::STATUS_MISS;
              state  <= S_DONE;
            end
          endcase
        end

        S_MRD: begin
          state <= S_MWR;
        end

        // add moves keys up from the top down, delete moves them down
        S_MWR: begin
          if (is_add) begin
            if (CW'(ptr) == hi) begin
              state <= S_INS;
            end else begin
              ptr   <= ptr - AW'(1);
              state <= S_MRD;
            end
          end else begin
            if (CW'(ptr) == cnt_m1) begin
              count <= cnt_m1;
              state <= S_DONE;
            end else begin
              ptr   <= ptr + AW'(1);
              state <= S_MRD;
            end
          end
        end

        S_INS: begin
          count <= count + CW'(1);
          state <= S_DONE;
        end

        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid     <= 1'b1;
            rsp_found     <= hit;
            rsp_position  <= (hi_wide > 32'd255) ? 8'hFF : hi_wide[7:0];
            rsp_status    <= status;
            rsp_occupancy <= (cnt_wide > 32'd511) ? 9'h1FF : cnt_wide[8:0];
            state         <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
